[rtl/tefu_pkg.sv]
// tefu_pkg: shared types and codes for the task event flag unit
// holds command and status codes, the input item and result structs
// no dependencies; imported by tefu_cmd_logic and task_event_flag_unit_top
`default_nettype none

package tefu_pkg;

    // width used for comparing task indexes against the task count
    localparam int IDX_CMP_W = 7;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_WAIT  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_TASK   = 3'd1,
        ST_BAD_MASK   = 3'd2,
        ST_NO_RUNNING = 3'd3,
        ST_EMPTY_WAIT = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [5:0]  target_task;
        logic [31:0] event_bits;
        logic [4:0]  running_task;
        logic        running_valid;
        logic        system_running;
        logic [7:0]  target_priority;
        logic [7:0]  running_priority;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] event_mask_out;
        logic        woke_task;
        logic        blocked_task;
        logic        schedule_request;
    } result_t;

endpackage

`default_nettype wire

[rtl/tefu_cmd_logic.sv]
// tefu_cmd_logic: combinational command evaluation for one task entry
// takes the registered item and the current entry, gives the result and the entry update
// depends on tefu_pkg
`default_nettype none

module tefu_cmd_logic
    import tefu_pkg::*;
#(
    parameter int NUM_TASKS  = 32,
    parameter int EVENT_BITS = 16
)
(
    input  item_t                 item,
    input  logic [EVENT_BITS-1:0] pend,
    input  logic [EVENT_BITS-1:0] wmask,
    input  logic                  waiting,
    output result_t               result,
    output logic                  wr_en,
    output logic [EVENT_BITS-1:0] pend_next,
    output logic [EVENT_BITS-1:0] wmask_next,
    output logic                  waiting_next
);

    localparam logic [31:0] LEGAL_MASK = 32'((64'd1 << EVENT_BITS) - 64'd1);
    localparam logic [IDX_CMP_W-1:0] TASK_LIMIT = IDX_CMP_W'(NUM_TASKS);

    function automatic logic [15:0] to_out(input logic [EVENT_BITS-1:0] v);
        logic [31:0] ext;
        begin
            ext = 32'(v);
            return ext[15:0];
        end
    endfunction

    logic                  mask_ok;
    logic                  bad_tgt;
    logic                  bad_run;
    logic [EVENT_BITS-1:0] bits;
    logic [EVENT_BITS-1:0] set_pend;
    logic                  wake;

    assign mask_ok  = (item.event_bits & ~LEGAL_MASK) == 32'd0;
    assign bits     = item.event_bits[EVENT_BITS-1:0];
    assign bad_tgt  = {1'b0, item.target_task} >= TASK_LIMIT;
    assign bad_run  = {2'b00, item.running_task} >= TASK_LIMIT;
    assign set_pend = pend | bits;
    assign wake     = waiting && (wmask != '0) && ((set_pend & wmask) != '0);

    always_comb
    begin
        result.status           = ST_OK;
        result.event_mask_out   = to_out(pend);
        result.woke_task        = 1'b0;
        result.blocked_task     = 1'b0;
        result.schedule_request = 1'b0;
        wr_en                   = 1'b0;
        pend_next               = pend;
        wmask_next              = wmask;
        waiting_next            = waiting;
        case (item.cmd)
            CMD_SET:
            begin
                if (bad_tgt)
                begin
                    result.status         = ST_BAD_TASK;
                    result.event_mask_out = 16'd0;
                end
                else if (!mask_ok)
                begin
                    result.status = ST_BAD_MASK;
                end
                else
                begin
                    wr_en                 = 1'b1;
                    pend_next             = set_pend;
                    result.event_mask_out = to_out(set_pend);
                    if (wake)
                    begin
                        wmask_next       = '0;
                        waiting_next     = 1'b0;
                        result.woke_task = 1'b1;
                        // only while the system runs: preempt a less urgent running task, always when none runs
                        result.schedule_request = item.system_running &&
                            (!item.running_valid ||
                             (item.target_priority < item.running_priority));
                    end
                end
            end
            CMD_GET:
            begin
                if (bad_tgt)
                begin
                    result.status         = ST_BAD_TASK;
                    result.event_mask_out = 16'd0;
                end
            end
            default:
            begin
                // wait and clear act on the running task
                if (!item.running_valid)
                begin
                    result.status         = ST_NO_RUNNING;
                    result.event_mask_out = 16'd0;
                end
                else if (bad_run)
                begin
                    result.status         = ST_BAD_TASK;
                    result.event_mask_out = 16'd0;
                end
                else if (!mask_ok)
                begin
                    result.status = ST_BAD_MASK;
                end
                else if (item.cmd == CMD_CLEAR)
                begin
                    wr_en                 = 1'b1;
                    pend_next             = pend & ~bits;
                    result.event_mask_out = to_out(pend & ~bits);
                end
                else if (bits == '0)
                begin
                    result.status = ST_EMPTY_WAIT;
                end
                else if ((pend & bits) != '0)
                begin
                    // consume matching events, no block
                    wr_en                 = 1'b1;
                    pend_next             = pend & ~bits;
                    wmask_next            = '0;
                    result.event_mask_out = to_out(pend & ~bits);
                end
                else
                begin
                    wr_en                   = 1'b1;
                    wmask_next              = bits;
                    waiting_next            = 1'b1;
                    result.blocked_task     = 1'b1;
                    result.schedule_request = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/task_event_flag_unit_top.sv]
// task_event_flag_unit_top: per-task event flag unit with stream command and result ports
// holds the task entry memory, entry valid bits, read bypass and the output register
// depends on tefu_pkg and tefu_cmd_logic
`default_nettype none

// One command is taken per clock cycle and produces exactly one result transfer.
// A command sits in the input stage, where the task entry read from the
// entry memory (one read and one write port) lands, and its result is then
// loaded into the output register on the master side; throughput is one
// command per cycle while the result side keeps taking transfers. Entry
// memory reset is handled by one valid bit per task: an entry never written
// reads as zero pending events, zero wait mask and not waiting, so the block is
// usable right after reset with no clearing pass. A command that hits the entry
// written by the command just ahead of it picks up the new value through a
// bypass register. Set and get address target_task; wait and clear address the
// running task. The flags woke_task, blocked_task and schedule_request report the
// ready-queue move and the scheduler call that the host must perform.
module task_event_flag_unit_top
    import tefu_pkg::*;
#(
    parameter int NUM_TASKS  = 32,
    parameter int EVENT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // target_task[5:0], event_bits[37:6], running_task[42:38], running_valid[43],
    // system_running[44], target_priority[52:45], running_priority[60:53], zero[63:61]
    input  wire logic [63:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], event_mask_out[18:3], woke_task[19], blocked_task[20],
    // schedule_request[21], zero[23:22]
    output logic [23:0]      m_tdata
);

    localparam int TIDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int ENTRY_W = 2 * EVENT_BITS + 1;

    // entry word layout: waiting flag, wait mask, pending events
    logic [ENTRY_W-1:0] entry_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] valid_reg;

    item_t               in_item;
    logic                accept;
    logic [5:0]          rd_sel;
    logic                rd_in_range;
    logic [TIDX_W-1:0]   rd_idx;

    logic                s1_valid_reg;
    item_t               s1_item_reg;
    logic [TIDX_W-1:0]   s1_idx_reg;
    logic [ENTRY_W-1:0]  rd_word_reg;
    logic                rd_valid_reg;
    logic                byp_hit_reg;
    logic [ENTRY_W-1:0]  byp_word_reg;

    logic [ENTRY_W-1:0]  cur_word;
    logic [ENTRY_W-1:0]  wr_word;
    result_t             res;
    logic                cl_wr_en;
    logic                wr_en;
    logic [EVENT_BITS-1:0] pend_next;
    logic [EVENT_BITS-1:0] wmask_next;
    logic                waiting_next;

    logic                out_load;
    logic                out_valid_reg;
    result_t             out_reg;

    // unpack the command transfer
    assign in_item.cmd              = cmd_t'(s_tuser);
    assign in_item.target_task      = s_tdata[5:0];
    assign in_item.event_bits       = s_tdata[37:6];
    assign in_item.running_task     = s_tdata[42:38];
    assign in_item.running_valid    = s_tdata[43];
    assign in_item.system_running   = s_tdata[44];
    assign in_item.target_priority  = s_tdata[52:45];
    assign in_item.running_priority = s_tdata[60:53];

    // stage handshake: input stage moves on when the output register frees up
    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    // entry address; out-of-range indexes read entry zero, the result is an error anyway
    assign rd_sel = ((in_item.cmd == CMD_SET) || (in_item.cmd == CMD_GET)) ?
                    in_item.target_task : {1'b0, in_item.running_task};
    assign rd_in_range = {1'b0, rd_sel} < IDX_CMP_W'(NUM_TASKS);
    assign rd_idx      = rd_in_range ? rd_sel[TIDX_W-1:0] : '0;

    // current entry: bypass from the write just done, else memory, else reset value
    assign cur_word = byp_hit_reg  ? byp_word_reg :
                      rd_valid_reg ? rd_word_reg  : '0;

    tefu_cmd_logic #(
        .NUM_TASKS  (NUM_TASKS),
        .EVENT_BITS (EVENT_BITS)
    ) u_cmd (
        .item         (s1_item_reg),
        .pend         (cur_word[EVENT_BITS-1:0]),
        .wmask        (cur_word[2*EVENT_BITS-1:EVENT_BITS]),
        .waiting      (cur_word[ENTRY_W-1]),
        .result       (res),
        .wr_en        (cl_wr_en),
        .pend_next    (pend_next),
        .wmask_next   (wmask_next),
        .waiting_next (waiting_next)
    );

    // entry update only when the command leaves the input stage
    assign wr_en   = out_load && cl_wr_en;
    assign wr_word = {waiting_next, wmask_next, pend_next};

    // entry memory, no reset; valid bits stand in for the cleared state
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[s1_idx_reg] <= wr_word;
        end
        if (accept)
        begin
            rd_word_reg <= entry_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[s1_idx_reg] <= 1'b1;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                rd_valid_reg <= valid_reg[rd_idx];
                // the read above sees the old word when the same entry is written now
                byp_hit_reg  <= wr_en && (s1_idx_reg == rd_idx);
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
                byp_hit_reg  <= 1'b0;
            end
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= in_item;
            s1_idx_reg   <= rd_idx;
            byp_word_reg <= wr_word;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.schedule_request, out_reg.blocked_task,
                       out_reg.woke_task, out_reg.event_mask_out, out_reg.status};

    // an error result never carries a flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_reg.status != ST_OK) |->
            !(out_reg.woke_task || out_reg.blocked_task || out_reg.schedule_request))
        else $error("flag set on an error result");

    // a block always asks for the scheduler and never comes with a wake
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.blocked_task |-> out_reg.schedule_request && !out_reg.woke_task)
        else $error("blocked result without schedule request or with wake");

    // bypass only applies to a command that is held in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        byp_hit_reg |-> s1_valid_reg)
        else $error("bypass hit with empty input stage");

    // a written entry is marked valid from the next cycle on
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(s1_idx_reg)])
        else $error("written entry not marked valid");

    // a finished result is loaded exactly when the input stage moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("result lost after leaving input stage");

endmodule

`default_nettype wire

[test/tb_task_event_flag_unit_top.sv]
// tb_task_event_flag_unit_top: self-checking bench for the task event flag unit
// models pending, wait mask and waiting state per task, streams commands and checks results
// depends on tefu_pkg and task_event_flag_unit_top
`default_nettype none

module tb_task_event_flag_unit_top
    import tefu_pkg::*;
();

    localparam int          TASK_COUNT  = 32;
    localparam logic [31:0] LEGAL_MASK  = 32'h0000_FFFF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          ITEMS_PER_PHASE = 500;

    // per-task event state plus the queue of results still owed by the block
    class event_flag_scoreboard;
        logic [15:0] task_pending [TASK_COUNT];
        logic [15:0] task_wait_mask [TASK_COUNT];
        logic        task_waiting [TASK_COUNT];
        result_t     due_results [$];
        int unsigned errors;
        int unsigned results_seen;

        function new();
            foreach (task_pending[i])
            begin
                task_pending[i]   = '0;
                task_wait_mask[i] = '0;
                task_waiting[i]   = 1'b0;
            end
            errors       = 0;
            results_seen = 0;
        endfunction

        // update the task state for one accepted command and queue its result
        function void apply_command(item_t it);
            result_t r;
            logic    mask_ok;
            int      t;
            r         = '0;
            r.status  = ST_OK;
            mask_ok   = (it.event_bits & ~LEGAL_MASK) == 32'h0;
            if (it.cmd == CMD_SET || it.cmd == CMD_GET)
            begin
                t = int'(it.target_task);
                if (t >= TASK_COUNT)
                    r.status = ST_BAD_TASK;
                else if (it.cmd == CMD_GET)
                    r.event_mask_out = task_pending[t];
                else if (!mask_ok)
                begin
                    r.status         = ST_BAD_MASK;
                    r.event_mask_out = task_pending[t];
                end
                else
                begin
                    task_pending[t] = task_pending[t] | it.event_bits[15:0];
                    if (task_waiting[t] && task_wait_mask[t] != '0 &&
                        (task_pending[t] & task_wait_mask[t]) != '0)
                    begin
                        task_wait_mask[t] = '0;
                        task_waiting[t]   = 1'b0;
                        r.woke_task       = 1'b1;
                        if (it.system_running)
                            r.schedule_request = it.running_valid ?
                                (it.target_priority < it.running_priority) : 1'b1;
                    end
                    r.event_mask_out = task_pending[t];
                end
            end
            else
            begin
                // wait and clear act on the running task
                t = int'(it.running_task);
                if (!it.running_valid)
                    r.status = ST_NO_RUNNING;
                else if (t >= TASK_COUNT)
                    r.status = ST_BAD_TASK;
                else if (!mask_ok)
                begin
                    r.status         = ST_BAD_MASK;
                    r.event_mask_out = task_pending[t];
                end
                else if (it.cmd == CMD_CLEAR)
                begin
                    task_pending[t]  = task_pending[t] & ~it.event_bits[15:0];
                    r.event_mask_out = task_pending[t];
                end
                else if (it.event_bits == 32'h0)
                begin
                    r.status         = ST_EMPTY_WAIT;
                    r.event_mask_out = task_pending[t];
                end
                else if ((task_pending[t] & it.event_bits[15:0]) != '0)
                begin
                    // events already there: consume them, waiting bit is left alone
                    task_pending[t]   = task_pending[t] & ~it.event_bits[15:0];
                    task_wait_mask[t] = '0;
                    r.event_mask_out  = task_pending[t];
                end
                else
                begin
                    task_wait_mask[t]  = it.event_bits[15:0];
                    task_waiting[t]    = 1'b1;
                    r.event_mask_out   = task_pending[t];
                    r.blocked_task     = 1'b1;
                    r.schedule_request = 1'b1;
                end
            end
            due_results.push_back(r);
        endfunction

        function void report_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: result %0d %s expected %0h actual %0h",
                         $time, results_seen, name, exp_v, act_v);
            end
        endfunction

        // compare one result transfer against the oldest queued result
        function void check_result(logic [23:0] word);
            result_t exp_r;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %0h, expected none", $time, word);
                return;
            end
            exp_r = due_results.pop_front();
            report_field("status", 32'(exp_r.status), 32'(word[2:0]));
            report_field("event_mask_out", 32'(exp_r.event_mask_out), 32'(word[18:3]));
            report_field("woke_task", 32'(exp_r.woke_task), 32'(word[19]));
            report_field("blocked_task", 32'(exp_r.blocked_task), 32'(word[20]));
            report_field("schedule_request", 32'(exp_r.schedule_request), 32'(word[21]));
            results_seen++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // target_task, event_bits, running_task, running_valid, system_running,
    // target_priority, running_priority, zero pad
    logic [63:0] s_tdata;
    // cmd
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // status, event_mask_out, woke_task, blocked_task, schedule_request, zero pad
    logic [23:0] m_tdata;

    event_flag_scoreboard sb;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned cycles = 0;

    task_event_flag_unit_top #(
        .NUM_TASKS  (32),
        .EVENT_BITS (16)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side stalls at random, rate set by the current phase
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);

    // watch both sides; a command and a result in the same cycle never belong together,
    // so noting the command first keeps the queue order right
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                item_t it;
                it.cmd              = cmd_t'(s_tuser);
                it.target_task      = s_tdata[5:0];
                it.event_bits       = s_tdata[37:6];
                it.running_task     = s_tdata[42:38];
                it.running_valid    = s_tdata[43];
                it.system_running   = s_tdata[44];
                it.target_priority  = s_tdata[52:45];
                it.running_priority = s_tdata[60:53];
                sb.apply_command(it);
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic item_t make_cmd(cmd_t c, int unsigned tgt, logic [31:0] bits,
                                       int unsigned run, bit rv, bit sys,
                                       int unsigned tp, int unsigned rp);
        item_t it;
        it.cmd              = c;
        it.target_task      = tgt[5:0];
        it.event_bits       = bits;
        it.running_task     = run[4:0];
        it.running_valid    = rv;
        it.system_running   = sys;
        it.target_priority  = tp[7:0];
        it.running_priority = rp[7:0];
        return it;
    endfunction

    // random command aimed at a few hot tasks so that waits, wakes and clears collide
    function automatic item_t random_cmd();
        item_t       it;
        int unsigned pick;
        it.cmd = cmd_t'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 85)
            it.target_task = 6'($urandom_range(3));
        else if (pick < 95)
            it.target_task = 6'($urandom_range(31));
        else
            it.target_task = 6'($urandom_range(63, 32));
        it.running_task = ($urandom_range(99) < 80) ? 5'($urandom_range(3)) :
                                                      5'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 60)
            it.event_bits = $urandom_range(15, 1);
        else if (pick < 80)
            it.event_bits = $urandom_range(16'hFFFF);
        else if (pick < 85)
            it.event_bits = 32'h0;
        else if (pick < 90)
            it.event_bits = 32'h0000_FFFF;
        else
            it.event_bits = $urandom | (32'h1 << $urandom_range(31, 16));
        it.running_valid    = ($urandom_range(99) < 90);
        it.system_running   = ($urandom_range(99) < 80);
        it.target_priority  = 8'($urandom_range(255));
        it.running_priority = 8'($urandom_range(255));
        return it;
    endfunction

    // drive one command and hold it until the block takes the transfer
    task automatic send_command(input item_t it);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {3'b000, it.running_priority, it.target_priority, it.system_running,
                     it.running_valid, it.running_task, it.event_bits, it.target_task};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        sb           = new();
        snd_idle_pct = 15;
        rcv_idle_pct = 87;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: error paths, extremes, and every wake / block outcome
        send_command(make_cmd(CMD_GET,   0,  32'h0,         0,  1, 1, 0,   0));
        send_command(make_cmd(CMD_GET,   63, 32'hFFFF_FFFF, 0,  1, 1, 0,   0));
        send_command(make_cmd(CMD_SET,   32, 32'h1,         0,  1, 1, 0,   0));
        // illegal bit just above the event field, pending mask still reported
        send_command(make_cmd(CMD_SET,   5,  32'h0001_0000, 0,  1, 1, 0,   0));
        send_command(make_cmd(CMD_SET,   5,  32'h0000_FFFF, 0,  1, 1, 0,   0));
        // no running task takes precedence over everything else
        send_command(make_cmd(CMD_CLEAR, 0,  32'hFFFF_FFFF, 5,  0, 1, 0,   0));
        send_command(make_cmd(CMD_WAIT,  0,  32'h0,         5,  0, 1, 0,   0));
        send_command(make_cmd(CMD_WAIT,  0,  32'h0,         5,  1, 1, 0,   0));
        send_command(make_cmd(CMD_WAIT,  0,  32'h8000,      5,  1, 1, 0,   0));
        send_command(make_cmd(CMD_CLEAR, 0,  32'hFFFF_FFFF, 5,  1, 1, 0,   0));
        send_command(make_cmd(CMD_CLEAR, 0,  32'h00FF,      5,  1, 1, 0,   0));
        // block, miss, then wake with preemption at extreme priorities
        send_command(make_cmd(CMD_WAIT,  0,  32'h0003,      7,  1, 1, 0,   0));
        send_command(make_cmd(CMD_SET,   7,  32'h0004,      0,  1, 1, 3,   10));
        send_command(make_cmd(CMD_SET,   7,  32'h0001,      0,  1, 1, 0,   255));
        // wake without preemption, lower urgency than the running task
        send_command(make_cmd(CMD_WAIT,  0,  32'h0010,      8,  1, 0, 0,   0));
        send_command(make_cmd(CMD_SET,   8,  32'h0010,      0,  1, 1, 255, 0));
        // wake with no running task while the system runs asks for the scheduler
        send_command(make_cmd(CMD_WAIT,  0,  32'h8000,      9,  1, 1, 0,   0));
        send_command(make_cmd(CMD_SET,   9,  32'h8000,      0,  0, 1, 100, 100));
        // wake before the scheduler has started never asks for it
        send_command(make_cmd(CMD_WAIT,  0,  32'h0100,      10, 1, 1, 0,   0));
        send_command(make_cmd(CMD_SET,   10, 32'h0100,      0,  1, 0, 0,   255));
        // consuming wait leaves the waiting bit set with an empty wait mask, so no wake
        send_command(make_cmd(CMD_WAIT,  0,  32'h0001,      11, 1, 1, 0,   0));
        send_command(make_cmd(CMD_SET,   11, 32'h0002,      0,  1, 1, 7,   7));
        send_command(make_cmd(CMD_WAIT,  0,  32'h0002,      11, 1, 1, 0,   0));
        send_command(make_cmd(CMD_SET,   11, 32'h0001,      0,  1, 1, 0,   9));
        send_command(make_cmd(CMD_SET,   31, 32'h0000_FFFF, 0,  1, 1, 7,   7));
        send_command(make_cmd(CMD_CLEAR, 0,  32'h0000_FFFF, 31, 1, 1, 0,   0));

        // random: sender light / receiver heavy, then swapped, then no idling
        for (int ph = 0; ph < 3; ph++)
        begin
            snd_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 87 : 0;
            rcv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 15 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_command(random_cmd());
        end
        s_tvalid <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        // leave room for anything stray
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
